// ===== rtl/ctu_neighbor_depth_context_macros.svh =====
// ============================================================================
// CTU neighbor depth context: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ============================================================================
`ifndef CTU_NEIGHBOR_DEPTH_CONTEXT_MACROS_SVH
`define CTU_NEIGHBOR_DEPTH_CONTEXT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CTU_NDC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CTU_NDC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ctu_ndc_pkg.sv =====
// ============================================================================
// CTU neighbor depth context package
// Shared types, constants and the per-result statistics function.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package ctu_ndc_pkg;

  localparam int MAX_DEPTH = 5;
  localparam int DEPTH_W = 3;
  localparam int NIB_W = 4;
  localparam int CELL_W = 2 * NIB_W;
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic signed [NIB_W-1:0] INVALID_DEPTH = -4'sd1;

  typedef struct packed {
    logic [DEPTH_W-1:0] qt;
    logic [DEPTH_W-1:0] mt;
  } entry_t;

  typedef struct packed {
    logic [NIB_W-1:0]   top_left;
    logic [NIB_W-1:0]   top;
    logic [NIB_W-1:0]   top_right;
    logic [NIB_W-1:0]   left;
    logic [NIB_W-1:0]   colocated_past;
    logic [NIB_W-1:0]   mean_depth;
    logic [DEPTH_W-1:0] most_common;
    logic [NIB_W-1:0]   highest;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_READ,
    ST_LOAD,
    ST_SEND_QT,
    ST_SEND_MT
  } back_state_t;

  function automatic logic [DEPTH_W-1:0] sat_depth(input logic [DEPTH_W-1:0] d);
    return (d > DEPTH_W'(MAX_DEPTH)) ? DEPTH_W'(MAX_DEPTH) : d;
  endfunction

  function automatic result_t ctu_ndc_eval(
    input logic signed [NIB_W-1:0] tl,
    input logic signed [NIB_W-1:0] t,
    input logic signed [NIB_W-1:0] tr,
    input logic signed [NIB_W-1:0] l,
    input logic signed [NIB_W-1:0] cp
  );
    logic signed [NIB_W-1:0] v [5];
    logic [2:0]              hist [MAX_DEPTH+1];
    logic [4:0]              sum;
    logic [2:0]              n;
    logic [2:0]              best_cnt;
    logic [DEPTH_W-1:0]      best;
    logic signed [NIB_W-1:0] high;
    logic [5:0]              x;
    logic [14:0]             prod;
    logic [NIB_W-1:0]        mean;
    result_t                 r;
    v[0] = tl;
    v[1] = t;
    v[2] = tr;
    v[3] = l;
    v[4] = cp;
    sum = '0;
    n = '0;
    high = INVALID_DEPTH;
    prod = '0;
    for (int d = 0; d <= MAX_DEPTH; d++) begin
      hist[d] = '0;
    end
    for (int i = 0; i < 5; i++) begin
      if (v[i] > high) begin
        high = v[i];
      end
      if (v[i] >= 0 && v[i] <= MAX_DEPTH) begin
        sum = sum + 5'(v[i][DEPTH_W-1:0]);
        n = n + 3'd1;
        for (int d = 0; d <= MAX_DEPTH; d++) begin
          if (v[i][DEPTH_W-1:0] == DEPTH_W'(d)) begin
            hist[d] = hist[d] + 3'd1;
          end
        end
      end
    end
    best = '0;
    best_cnt = hist[0];
    for (int i = 1; i <= MAX_DEPTH; i++) begin
      if (hist[i] > best_cnt) begin
        best = DEPTH_W'(i);
        best_cnt = hist[i];
      end
    end
    // Rounded mean is (2*sum + n) / (2*n); odd divisors use scaled reciprocals.
    x = {sum, 1'b0} + 6'(n);
    case (n)
      3'd1: mean = NIB_W'(sum);
      3'd2: mean = NIB_W'((sum + 5'd1) >> 1);
      3'd3: begin
        prod = 15'(x) * 15'd43;
        mean = NIB_W'(prod >> 8);
      end
      3'd4: mean = NIB_W'((sum + 5'd2) >> 2);
      3'd5: begin
        prod = 15'(x) * 15'd205;
        mean = NIB_W'(prod >> 11);
      end
      default: mean = INVALID_DEPTH;
    endcase
    r.top_left = tl;
    r.top = t;
    r.top_right = tr;
    r.left = l;
    r.colocated_past = cp;
    r.mean_depth = mean;
    r.most_common = best;
    r.highest = high;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ctu_ndc_front.sv =====
// ============================================================================
// CTU neighbor depth context: front end
// Accepts coding units, keeps the running depth maxima of the current CTU and
// queues the final maxima when a unit ends its CTU.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module ctu_ndc_front import ctu_ndc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,    // [2:0] qt_depth, [5:3] mt_depth, [7:6] zero
  input  logic       s_tuser,    // [0] is_luma
  input  logic       s_tlast,
  output logic       push_valid,
  input  logic       push_ready,
  output entry_t     push_entry
);

  logic [DEPTH_W-1:0] run_qt;
  logic [DEPTH_W-1:0] run_mt;
  logic [DEPTH_W-1:0] qt_sat;
  logic [DEPTH_W-1:0] mt_sat;
  logic [DEPTH_W-1:0] qt_upd;
  logic [DEPTH_W-1:0] mt_upd;
  logic               accept;

  assign s_tready = push_ready;
  assign accept = s_tvalid && s_tready;
  assign push_valid = accept && s_tlast;

  always_comb begin
    qt_sat = sat_depth(s_tdata[2:0]);
    mt_sat = sat_depth(s_tdata[5:3]);
    qt_upd = (s_tuser && qt_sat > run_qt) ? qt_sat : run_qt;
    mt_upd = (s_tuser && mt_sat > run_mt) ? mt_sat : run_mt;
    push_entry.qt = qt_upd;
    push_entry.mt = mt_upd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_qt <= '0;
      run_mt <= '0;
    end else if (accept) begin
      if (s_tlast) begin
        run_qt <= '0;
        run_mt <= '0;
      end else begin
        run_qt <= qt_upd;
        run_mt <= mt_upd;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ctu_ndc_queue.sv =====
// ============================================================================
// CTU neighbor depth context: decoupling queue
// Short FIFO of CTU maxima between the front end and the map sequencer.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module ctu_ndc_queue import ctu_ndc_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  entry_t in_entry,
  output logic   out_valid,
  input  logic   out_pop,
  output entry_t out_entry
);

  entry_t                 slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;
  logic                   do_push;
  logic                   do_pop;

  assign in_ready = (count != QUEUE_CNT_W'(QUEUE_DEPTH));
  assign out_valid = (count != '0);
  assign out_entry = slots[rd_ptr];
  assign do_push = in_valid && in_ready;
  assign do_pop = out_pop && out_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= in_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QUEUE_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QUEUE_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QUEUE_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QUEUE_CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ctu_ndc_bank.sv =====
// ============================================================================
// CTU neighbor depth context: map bank
// Row-wide depth map memory with per-cell write enables and a registered read.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module ctu_ndc_bank import ctu_ndc_pkg::*; #(
  parameter int COLS = 64,
  parameter int ROWS = 64,
  parameter int ROW_W = 6
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [ROW_W-1:0]           waddr,
  input  logic [COLS-1:0]            wmask,
  input  logic [COLS-1:0][CELL_W-1:0] wdata,
  input  logic [ROW_W-1:0]           raddr,
  output logic [COLS-1:0][CELL_W-1:0] rdata
);

  logic [COLS-1:0][CELL_W-1:0] mem [ROWS];

  always_ff @(posedge clk) begin
    for (int c = 0; c < COLS; c++) begin
      if (we && wmask[c]) begin
        mem[waddr][c] <= wdata[c];
      end
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/ctu_ndc_back.sv =====
// ============================================================================
// CTU neighbor depth context: map sequencer
// Stores CTU maxima in ping-pong row memories, tracks the raster position,
// swaps frames and produces the quadtree and multitype result pair.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none
`include "ctu_neighbor_depth_context_macros.svh"

module ctu_ndc_back import ctu_ndc_pkg::*; #(
  parameter int MAX_COLUMNS = 64,
  parameter int MAX_ROWS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [6:0]  ctu_columns,
  input  logic [6:0]  ctu_rows,
  input  logic        q_valid,
  output logic        q_pop,
  input  entry_t      q_entry,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,
  output logic        m_tuser,
  output logic        m_tlast
);

  localparam int COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CCNT_W = $clog2(MAX_COLUMNS + 1);
  localparam int RCNT_W = $clog2(MAX_ROWS + 1);

  back_state_t state;
  back_state_t state_next;

  logic [COL_W-1:0]    column_pos;
  logic [ROW_W-1:0]    row_pos;
  logic                cur_bank;
  logic [MAX_ROWS-1:0] cur_valid;
  logic [MAX_ROWS-1:0] past_valid;
  entry_t              wr_entry;
  result_t             res_qt;
  result_t             res_mt;
  result_t             res_out;

  logic [CCNT_W-1:0]   cols_eff;
  logic [RCNT_W-1:0]   rows_eff;
  logic [CCNT_W-1:0]   col_next_cnt;
  logic [RCNT_W-1:0]   row_next_cnt;
  logic                col_wrap;
  logic                row_wrap;
  logic [MAX_ROWS-1:0] row_bit;
  logic [COL_W-1:0]    col_m1;
  logic [COL_W-1:0]    col_p1;
  logic [ROW_W-1:0]    row_m1;

  logic                          bank_we [2];
  logic [ROW_W-1:0]              bank_raddr [2];
  logic [MAX_COLUMNS-1:0]              wmask;
  logic [MAX_COLUMNS-1:0][CELL_W-1:0]  wdata;
  logic [MAX_COLUMNS-1:0][CELL_W-1:0]  rdata [2];
  logic [MAX_COLUMNS-1:0][CELL_W-1:0]  top_row;
  logic [MAX_COLUMNS-1:0][CELL_W-1:0]  past_row;

  logic                    has_top;
  logic                    has_left;
  logic                    has_tr;
  logic                    has_past;
  logic signed [NIB_W-1:0] v_tl [2];
  logic signed [NIB_W-1:0] v_t [2];
  logic signed [NIB_W-1:0] v_tr [2];
  logic signed [NIB_W-1:0] v_l [2];
  logic signed [NIB_W-1:0] v_cp [2];
  result_t                 res_calc [2];

  always_comb begin
    if (ctu_columns == '0) begin
      cols_eff = CCNT_W'(1);
    end else if (32'(ctu_columns) > MAX_COLUMNS) begin
      cols_eff = CCNT_W'(MAX_COLUMNS);
    end else begin
      cols_eff = CCNT_W'(ctu_columns);
    end
    if (ctu_rows == '0) begin
      rows_eff = RCNT_W'(1);
    end else if (32'(ctu_rows) > MAX_ROWS) begin
      rows_eff = RCNT_W'(MAX_ROWS);
    end else begin
      rows_eff = RCNT_W'(ctu_rows);
    end
    col_next_cnt = CCNT_W'(column_pos) + CCNT_W'(1);
    row_next_cnt = RCNT_W'(row_pos) + RCNT_W'(1);
    col_wrap = (col_next_cnt >= cols_eff);
    row_wrap = (row_next_cnt >= rows_eff);
    row_bit = MAX_ROWS'(1) << row_pos;
    col_m1 = (column_pos != '0) ? column_pos - COL_W'(1) : '0;
    row_m1 = (row_pos != '0) ? row_pos - ROW_W'(1) : '0;
  end

  always_comb begin
    case (state)
      ST_IDLE:    state_next = q_valid ? ST_WRITE : ST_IDLE;
      ST_WRITE:   state_next = ST_READ;
      ST_READ:    state_next = ST_LOAD;
      ST_LOAD:    state_next = ST_SEND_QT;
      ST_SEND_QT: state_next = m_tready ? ST_SEND_MT : ST_SEND_QT;
      ST_SEND_MT: begin
        if (m_tready) begin
          state_next = q_valid ? ST_WRITE : ST_IDLE;
        end else begin
          state_next = ST_SEND_MT;
        end
      end
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop = 1'b0;
    m_tvalid = 1'b0;
    m_tuser = 1'b0;
    res_out = res_qt;
    case (state)
      ST_IDLE:    q_pop = q_valid;
      ST_SEND_QT: m_tvalid = 1'b1;
      ST_SEND_MT: begin
        m_tvalid = 1'b1;
        m_tuser = 1'b1;
        res_out = res_mt;
        q_pop = m_tready && q_valid;
      end
      default:    q_pop = 1'b0;
    endcase
    m_tlast = m_tuser;
    m_tdata = {1'b0, res_out.highest, res_out.most_common, res_out.mean_depth,
               res_out.colocated_past, res_out.left, res_out.top_right,
               res_out.top, res_out.top_left};
  end

  always_comb begin
    for (int c = 0; c < MAX_COLUMNS; c++) begin
      if (COL_W'(c) == column_pos) begin
        wdata[c] = {1'b0, wr_entry.mt, 1'b0, wr_entry.qt};
        wmask[c] = 1'b1;
      end else begin
        wdata[c] = {INVALID_DEPTH, INVALID_DEPTH};
        wmask[c] = !cur_valid[row_pos];
      end
    end
  end

  for (genvar b = 0; b < 2; b++) begin : g_bank
    assign bank_we[b] = (state == ST_WRITE) && (cur_bank == 1'(b));
    assign bank_raddr[b] = (cur_bank == 1'(b)) ? row_m1 : row_pos;

    ctu_ndc_bank #(
      .COLS  (MAX_COLUMNS),
      .ROWS  (MAX_ROWS),
      .ROW_W (ROW_W)
    ) u_bank (
      .clk   (clk),
      .we    (bank_we[b]),
      .waddr (row_pos),
      .wmask (wmask),
      .wdata (wdata),
      .raddr (bank_raddr[b]),
      .rdata (rdata[b])
    );
  end

  always_comb begin
    top_row = cur_bank ? rdata[1] : rdata[0];
    past_row = cur_bank ? rdata[0] : rdata[1];
    has_top = (row_pos != '0) && cur_valid[row_m1];
    has_left = (column_pos != '0);
    has_tr = has_top && (col_next_cnt < cols_eff);
    has_past = past_valid[row_pos];
    col_p1 = has_tr ? COL_W'(col_next_cnt) : '0;
    for (int k = 0; k < 2; k++) begin
      v_tl[k] = (has_top && has_left) ? top_row[col_m1][NIB_W*k +: NIB_W] : INVALID_DEPTH;
      v_t[k] = has_top ? top_row[column_pos][NIB_W*k +: NIB_W] : INVALID_DEPTH;
      v_tr[k] = has_tr ? top_row[col_p1][NIB_W*k +: NIB_W] : INVALID_DEPTH;
      v_cp[k] = has_past ? past_row[column_pos][NIB_W*k +: NIB_W] : INVALID_DEPTH;
    end
    v_l[0] = has_left ? {1'b0, wr_entry.qt} : INVALID_DEPTH;
    v_l[1] = has_left ? {1'b0, wr_entry.mt} : INVALID_DEPTH;
    for (int k = 0; k < 2; k++) begin
      res_calc[k] = ctu_ndc_eval(v_tl[k], v_t[k], v_tr[k], v_l[k], v_cp[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      wr_entry <= q_entry;
    end
    if (state == ST_LOAD) begin
      res_qt <= res_calc[0];
      res_mt <= res_calc[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      column_pos <= '0;
      row_pos <= '0;
      cur_bank <= 1'b0;
      cur_valid <= '0;
      past_valid <= '0;
    end else begin
      state <= state_next;
      if (state == ST_WRITE) begin
        if (!col_wrap) begin
          column_pos <= COL_W'(col_next_cnt);
          cur_valid <= cur_valid | row_bit;
        end else begin
          column_pos <= '0;
          if (!row_wrap) begin
            row_pos <= ROW_W'(row_next_cnt);
            cur_valid <= cur_valid | row_bit;
          end else begin
            row_pos <= '0;
            cur_bank <= ~cur_bank;
            past_valid <= cur_valid | row_bit;
            cur_valid <= '0;
          end
        end
      end
    end
  end

  `CTU_NDC_ASSERT_NOW(a_pop_has_item, q_pop, q_valid, "queue popped while empty")
  `CTU_NDC_ASSERT_NEXT(a_pair_order, state == ST_SEND_QT && m_tready, state == ST_SEND_MT, "multitype result did not follow quadtree result")
  `CTU_NDC_ASSERT_NEXT(a_frame_swap, state == ST_WRITE && col_wrap && row_wrap, cur_valid == '0 && cur_bank != $past(cur_bank), "frame end did not swap banks and clear rows")
  `CTU_NDC_ASSERT_NEXT(a_left_edge, state == ST_LOAD && column_pos == '0, res_qt.left == INVALID_DEPTH && res_mt.left == INVALID_DEPTH, "left neighbor present in first column")

endmodule

`default_nettype wire

// ===== rtl/ctu_neighbor_depth_context.sv =====
// A CTU-ending unit passes the queue and the pop, write, row read and load states
// before its quadtree result is offered; the multitype result follows in the
// cycle after the quadtree one is taken. Units are taken one per cycle while the
// queue has room; CTU-ending units are processed one at a time (write, row read,
// compute, two results). Reset clears position, maxima, queue and row valid bits;
// map memories are not swept, rows never written read as invalid (-1).
// ============================================================================
// CTU neighbor depth context: top level
// Configuration registers, front end, decoupling queue and map sequencer.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module ctu_neighbor_depth_context import ctu_ndc_pkg::*; #(
  parameter int MAX_COLUMNS = 64,
  parameter int MAX_ROWS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [2:0] qt_depth, [5:3] mt_depth, [7:6] zero
  input  logic        s_tuser,   // [0] is_luma
  input  logic        s_tlast,   // ends_ctu
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [3:0] top_left, [7:4] top, [11:8] top_right,
                                 // [15:12] left, [19:16] colocated_past,
                                 // [23:20] mean_depth, [26:24] most_common,
                                 // [30:27] highest, [31] zero
  output logic        m_tuser,   // [0] tree_kind
  output logic        m_tlast,   // last
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic REG_COLUMNS = 1'b0;
  localparam logic REG_ROWS = 1'b1;

  logic [6:0] ctu_columns;
  logic [6:0] ctu_rows;
  logic       cfg_write;
  logic       push_valid;
  logic       push_ready;
  entry_t     push_entry;
  logic       q_valid;
  logic       q_pop;
  entry_t     q_entry;

  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_ROWS) ? {25'd0, ctu_rows} : {25'd0, ctu_columns};

  always_ff @(posedge clk) begin
    if (rst) begin
      ctu_columns <= 7'd15;
      ctu_rows <= 7'd9;
    end else if (cfg_write) begin
      if (paddr[2] == REG_COLUMNS) begin
        ctu_columns <= pwdata[6:0];
      end else begin
        ctu_rows <= pwdata[6:0];
      end
    end
  end

  ctu_ndc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .s_tlast    (s_tlast),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  ctu_ndc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (push_valid),
    .in_ready  (push_ready),
    .in_entry  (push_entry),
    .out_valid (q_valid),
    .out_pop   (q_pop),
    .out_entry (q_entry)
  );

  ctu_ndc_back #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .ctu_columns (ctu_columns),
    .ctu_rows    (ctu_rows),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .q_entry     (q_entry),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast)
  );

endmodule

`default_nettype wire
